// ===== src/mwua_pkg.sv =====
// Shared types and constants of the modular weighted update accumulator.
package mwua_pkg;

    localparam int unsigned MODULUS = 3329;

    localparam int ELEM_W   = 13;
    localparam int IDX_W    = 12;
    localparam int UPD_W    = 16;
    localparam int WGT_W    = 32;
    localparam int COUNT_W  = 13;
    localparam int PROD_W   = 48;
    localparam int MAG_W    = 12;
    localparam int DIV_STEPS = 12;
    localparam int STEP_W   = 4;

    // Folding a 48-bit magnitude in 12-bit chunks: the weight of each chunk
    // reduced modulo 3329 (2^12, 2^24 and 2^36 respectively).
    localparam int CHUNK_W  = 12;
    localparam int FOLD_W   = 26;
    localparam int unsigned FOLD_C1 = 767;
    localparam int unsigned FOLD_C2 = 2385;
    localparam int unsigned FOLD_C3 = 1674;
    // Below this bound one conditional subtraction completes the reduction.
    localparam int unsigned FOLD_LIMIT = 2 * MODULUS;

    typedef enum logic [1:0] {
        ACT_ACCUMULATE = 2'd0,
        ACT_FINALIZE   = 2'd1,
        ACT_READ       = 2'd2,
        ACT_CLEAR      = 2'd3
    } t_action;

    typedef enum logic {
        REG_ELEMENT_COUNT = 1'b0,
        REG_ENABLED       = 1'b1
    } t_reg_index;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_SUM   = 7'b0001000,
        ST_FOLD  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

endpackage

// ===== src/modular_weighted_update_accumulator.sv =====
// Top level of the modular weighted update accumulator.
//
// The block holds MAX_ELEMENTS signed 13-bit elements in one synchronous RAM.
// Each input request names an action (accumulate, finalise, read or clear) and
// an element; every request yields exactly one result request carrying the new
// element value and a status bit. Both data channels use valid and ready, and a
// separate configuration channel, always ready, writes the element count and
// the enable bit.
//
// After reset the block sweeps the RAM to zero, one entry per cycle; input
// ready stays low during the sweep while configuration writes are accepted
// as usual.
//
// Requests are processed one at a time. A rejected request goes straight to
// the done state; read and clear pass through the read state, accumulate
// then through the sum and fold states and finalise through the divide state.
// Accumulate reduces the magnitude of the sum modulo 3329 by folding 12-bit
// chunks, one fold per cycle; finalise runs a 12-step restoring divider on
// the element magnitude. Input ready returns in the same cycle as the result
// is loaded into the output register.
// If the receiver stalls, the next request holds at the end of its processing
// until the output register frees up.
module modular_weighted_update_accumulator #(
    parameter int MAX_ELEMENTS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_action,
    input  logic [mwua_pkg::IDX_W-1:0]          i_element_index,
    input  logic signed [mwua_pkg::UPD_W-1:0]   i_update_value,
    input  logic [mwua_pkg::WGT_W-1:0]          i_weight_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mwua_pkg::ELEM_W-1:0]  o_element_value,
    output logic                                o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [mwua_pkg::COUNT_W-1:0]        i_cfg_data
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    mwua_pkg::t_state r_state;
    mwua_pkg::t_state n_state;

    logic [mwua_pkg::COUNT_W-1:0] r_count;
    logic                         r_enabled;
    logic [AW-1:0]                r_clr_addr;

    // Latched request.
    mwua_pkg::t_action                r_action;
    logic [AW-1:0]                    r_addr;
    logic signed [mwua_pkg::UPD_W-1:0] r_upd;
    logic [mwua_pkg::WGT_W-1:0]       r_weight;
    logic                             r_reject;

    // Datapath registers.
    logic signed [mwua_pkg::ELEM_W-1:0] r_elem;
    logic signed [mwua_pkg::PROD_W-1:0] r_prod;
    logic                               r_neg;
    logic [mwua_pkg::PROD_W-1:0]        r_mod;
    logic [mwua_pkg::WGT_W-1:0]         r_rem;
    logic [mwua_pkg::MAG_W-1:0]         r_quo;
    logic [mwua_pkg::WGT_W-1:0]         r_divisor;
    logic [mwua_pkg::STEP_W-1:0]        r_step;
    logic signed [mwua_pkg::ELEM_W-1:0] r_result;

    logic                               r_out_valid;
    logic signed [mwua_pkg::ELEM_W-1:0] r_out_value;
    logic                               r_out_status;

    logic                               w_accept;
    logic                               w_reject_in;
    logic [mwua_pkg::ELEM_W-1:0]        w_rdata;
    logic                               w_we;
    logic [AW-1:0]                      w_waddr;
    logic [mwua_pkg::ELEM_W-1:0]        w_wdata;
    logic signed [48:0]                 w_prod;
    logic signed [48:0]                 w_sum;
    logic signed [48:0]                 w_abs;
    logic [mwua_pkg::ELEM_W-1:0]        w_rd_abs;
    logic [mwua_pkg::FOLD_W-1:0]        w_fold;
    logic                               w_fold_done;
    logic [mwua_pkg::MAG_W-1:0]         w_mod_mag;
    logic [mwua_pkg::WGT_W:0]           w_trial;
    logic                               w_ge;
    logic [mwua_pkg::MAG_W-1:0]         w_quo_next;
    logic                               w_out_free;

    assign o_in_ready  = (r_state == mwua_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // A request is turned away when disabled, out of range, or when
    // finalising with a zero total weight.
    assign w_reject_in = !r_enabled
        || (32'(i_element_index) >= 32'(r_count))
        || (32'(i_element_index) >= 32'(MAX_ELEMENTS))
        || ((i_action == mwua_pkg::ACT_FINALIZE) && (i_weight_value == '0));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_enabled <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mwua_pkg::REG_ELEMENT_COUNT: r_count   <= i_cfg_data;
                mwua_pkg::REG_ENABLED:       r_enabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mwua_ram #(
        .WIDTH(mwua_pkg::ELEM_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(AW'(i_element_index)),
        .o_rdata(w_rdata)
    );

    // The write-back happens in the done state; rewriting the same value
    // while the output is stalled is harmless.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_result;
        if (r_state == mwua_pkg::ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (r_state == mwua_pkg::ST_DONE) begin
            w_we = !r_reject;
        end
    end

    // Arithmetic.
    assign w_prod   = $signed(r_upd) * $signed({1'b0, r_weight});
    assign w_sum    = {r_prod[mwua_pkg::PROD_W-1], r_prod}
                    + {{36{r_elem[mwua_pkg::ELEM_W-1]}}, r_elem};
    assign w_abs    = w_sum[48] ? -w_sum : w_sum;
    assign w_rd_abs = w_rdata[mwua_pkg::ELEM_W-1] ? (~w_rdata + 13'd1) : w_rdata;

    // One fold keeps the value modulo 3329 and shrinks it while it is at
    // least 4096, so the loop always reaches the final bound.
    assign w_fold =
          mwua_pkg::FOLD_W'(r_mod[11:0])
        + mwua_pkg::FOLD_W'(r_mod[23:12]) * mwua_pkg::FOLD_W'(mwua_pkg::FOLD_C1)
        + mwua_pkg::FOLD_W'(r_mod[35:24]) * mwua_pkg::FOLD_W'(mwua_pkg::FOLD_C2)
        + mwua_pkg::FOLD_W'(r_mod[47:36]) * mwua_pkg::FOLD_W'(mwua_pkg::FOLD_C3);
    assign w_fold_done = r_mod < mwua_pkg::PROD_W'(mwua_pkg::FOLD_LIMIT);
    assign w_mod_mag   = (r_mod[12:0] >= 13'(mwua_pkg::MODULUS))
                       ? mwua_pkg::MAG_W'(r_mod[12:0] - 13'(mwua_pkg::MODULUS))
                       : r_mod[mwua_pkg::MAG_W-1:0];

    assign w_trial    = {r_rem, r_quo[mwua_pkg::MAG_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_divisor};
    assign w_quo_next = {r_quo[mwua_pkg::MAG_W-2:0], w_ge};

    always_comb begin
        n_state = r_state;
        case (r_state)
            mwua_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(MAX_ELEMENTS - 1)) begin
                    n_state = mwua_pkg::ST_IDLE;
                end
            end
            mwua_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_reject_in ? mwua_pkg::ST_DONE : mwua_pkg::ST_READ;
                end
            end
            mwua_pkg::ST_READ: begin
                case (r_action)
                    mwua_pkg::ACT_ACCUMULATE: n_state = mwua_pkg::ST_SUM;
                    mwua_pkg::ACT_FINALIZE:   n_state = mwua_pkg::ST_DIV;
                    default:                  n_state = mwua_pkg::ST_DONE;
                endcase
            end
            mwua_pkg::ST_SUM: n_state = mwua_pkg::ST_FOLD;
            mwua_pkg::ST_FOLD: begin
                if (w_fold_done) begin
                    n_state = mwua_pkg::ST_DONE;
                end
            end
            mwua_pkg::ST_DIV: begin
                if (r_step == mwua_pkg::STEP_W'(mwua_pkg::DIV_STEPS - 1)) begin
                    n_state = mwua_pkg::ST_DONE;
                end
            end
            mwua_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = mwua_pkg::ST_IDLE;
                end
            end
            default: n_state = mwua_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mwua_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mwua_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mwua_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_action <= mwua_pkg::t_action'(i_action);
                    r_addr   <= AW'(i_element_index);
                    r_upd    <= i_update_value;
                    r_weight <= i_weight_value;
                    r_reject <= w_reject_in;
                    r_result <= '0;
                end
            end
            mwua_pkg::ST_READ: begin
                r_elem    <= $signed(w_rdata);
                r_prod    <= w_prod[mwua_pkg::PROD_W-1:0];
                r_result  <= (r_action == mwua_pkg::ACT_READ) ? $signed(w_rdata) : '0;
                // Finalise divides the element magnitude by the weight.
                r_neg     <= w_rdata[mwua_pkg::ELEM_W-1];
                r_rem     <= '0;
                r_quo     <= w_rd_abs[mwua_pkg::MAG_W-1:0];
                r_divisor <= r_weight;
                r_step    <= '0;
            end
            mwua_pkg::ST_SUM: begin
                r_neg <= w_sum[48];
                r_mod <= w_abs[mwua_pkg::PROD_W-1:0];
            end
            mwua_pkg::ST_FOLD: begin
                // Sign of the truncated remainder follows the dividend.
                if (w_fold_done) begin
                    r_result <= r_neg ? -$signed({1'b0, w_mod_mag})
                                      : $signed({1'b0, w_mod_mag});
                end else begin
                    r_mod <= mwua_pkg::PROD_W'(w_fold);
                end
            end
            mwua_pkg::ST_DIV: begin
                r_rem  <= w_ge ? mwua_pkg::WGT_W'(w_trial - {1'b0, r_divisor})
                               : w_trial[mwua_pkg::WGT_W-1:0];
                r_quo  <= w_quo_next;
                r_step <= r_step + mwua_pkg::STEP_W'(1);
                // The quotient never exceeds 3328, so no further reduction is due.
                if (r_step == mwua_pkg::STEP_W'(mwua_pkg::DIV_STEPS - 1)) begin
                    r_result <= r_neg ? -$signed({1'b0, w_quo_next})
                                      : $signed({1'b0, w_quo_next});
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == mwua_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_state == mwua_pkg::ST_DONE && w_out_free) begin
            r_out_value  <= r_reject ? '0 : r_result;
            r_out_status <= r_reject;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_element_value = r_out_value;
    assign o_status        = r_out_status;

endmodule

// ===== src/mwua_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mwua_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb_modular_weighted_update_accumulator.sv =====
// Self-checking testbench of the modular weighted update accumulator.
module tb_modular_weighted_update_accumulator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 4096;
    // Idle margin after each drain; it comfortably covers the slowest request.
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        mwua_pkg::t_action                    action;
        logic [mwua_pkg::IDX_W-1:0]           index;
        logic signed [mwua_pkg::UPD_W-1:0]    update;
        logic [mwua_pkg::WGT_W-1:0]           weight;
    } t_request;

    typedef struct {
        logic signed [mwua_pkg::ELEM_W-1:0]   value;
        logic                                 status;
    } t_result;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic [1:0]                           i_action;
    logic [mwua_pkg::IDX_W-1:0]           i_element_index;
    logic signed [mwua_pkg::UPD_W-1:0]    i_update_value;
    logic [mwua_pkg::WGT_W-1:0]           i_weight_value;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic signed [mwua_pkg::ELEM_W-1:0]   o_element_value;
    logic                                 o_status;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic                                 i_cfg_index;
    logic [mwua_pkg::COUNT_W-1:0]         i_cfg_data;

    // Requests waiting to be driven, and results that the predictor expects,
    // oldest first.
    t_request pending_requests[$];
    t_result  expected_results[$];

    // The testbench's own view of the accumulator state and its registers.
    logic signed [mwua_pkg::ELEM_W-1:0]   shadow_store[STORE_DEPTH];
    logic [mwua_pkg::COUNT_W-1:0]         shadow_count;
    logic                                 shadow_enabled;

    int unsigned send_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned failures;
    t_request    current_request;

    modular_weighted_update_accumulator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_element_index (i_element_index),
        .i_update_value  (i_update_value),
        .i_weight_value  (i_weight_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_element_value (o_element_value),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Works out the result of one accepted request and updates the shadow
    // store. The arithmetic is done in 64 bits, where SystemVerilog's division
    // and remainder truncate toward zero, as the block requires.
    function automatic t_result apply_request(input t_request req);
        t_result      res;
        int unsigned  limit;
        longint       elem;
        limit = (shadow_count < STORE_DEPTH) ? shadow_count : STORE_DEPTH;
        res.value  = '0;
        res.status = 1'b1;
        // A disabled block, an index outside the active range and a finalise
        // with zero total weight are all rejected without touching the store.
        if (!shadow_enabled || req.index >= limit ||
            (req.action == mwua_pkg::ACT_FINALIZE && req.weight == '0)) begin
            return res;
        end
        elem = longint'(shadow_store[req.index]);
        case (req.action)
            mwua_pkg::ACT_ACCUMULATE: begin
                elem = (elem + longint'(req.update) * longint'(req.weight))
                       % longint'(mwua_pkg::MODULUS);
            end
            mwua_pkg::ACT_FINALIZE: begin
                elem = (elem / longint'(req.weight)) % longint'(mwua_pkg::MODULUS);
            end
            mwua_pkg::ACT_READ: begin
            end
            default: begin
                elem = 0;
            end
        endcase
        shadow_store[req.index] = elem[mwua_pkg::ELEM_W-1:0];
        res.value  = elem[mwua_pkg::ELEM_W-1:0];
        res.status = 1'b0;
        return res;
    endfunction

    // Driver: predicts each request as it is accepted, then either holds the
    // next one on the bus or idles at the chosen rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid      <= 1'b0;
            i_action        <= mwua_pkg::ACT_READ;
            i_element_index <= '0;
            i_update_value  <= '0;
            i_weight_value  <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(apply_request(current_request));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    current_request = pending_requests.pop_front();
                    i_in_valid      <= 1'b1;
                    i_action        <= current_request.action;
                    i_element_index <= current_request.index;
                    i_update_value  <= current_request.update;
                    i_weight_value  <= current_request.weight;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation and
    // chooses whether to stall the next cycle.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: element_value %0d status %0b",
                           o_element_value, o_status);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_element_value !== want.value) begin
                        $error("element_value: expected %0d, actual %0d",
                               want.value, o_element_value);
                        failures++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0b, actual %0b",
                               want.status, o_status);
                        failures++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Writes one register through the configuration channel while the block
    // is idle, and mirrors the write in the shadow registers.
    task automatic write_register(input mwua_pkg::t_reg_index reg_sel,
                                  input logic [mwua_pkg::COUNT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_sel;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (reg_sel == mwua_pkg::REG_ELEMENT_COUNT) begin
            shadow_count = data;
        end else begin
            shadow_enabled = data[0];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_request(input mwua_pkg::t_action act, input int unsigned idx,
                                 input logic signed [mwua_pkg::UPD_W-1:0] upd,
                                 input logic [mwua_pkg::WGT_W-1:0] wgt);
        t_request req;
        req.action = act;
        req.index  = idx[mwua_pkg::IDX_W-1:0];
        req.update = upd;
        req.weight = wgt;
        pending_requests.push_back(req);
    endtask

    // Lets every queued request through and every result out, then waits for
    // the block to settle.
    task automatic drain;
        do @(posedge i_clk);
        while (pending_requests.size() > 0 || i_in_valid ||
               expected_results.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random requests: mostly inside the active range with a bias toward a
    // few hot elements so that values build up, weights either small (zero
    // included) or full range.
    task automatic queue_random(input int unsigned count);
        int unsigned limit;
        int unsigned idx;
        logic [mwua_pkg::WGT_W-1:0] wgt;
        limit = (shadow_count < STORE_DEPTH) ? shadow_count : STORE_DEPTH;
        repeat (count) begin
            case ($urandom_range(9))
                0:       idx = $urandom_range(STORE_DEPTH - 1);
                1, 2, 3: idx = $urandom_range(3);
                default: idx = (limit > 0) ? $urandom_range(limit - 1) : 0;
            endcase
            case ($urandom_range(5))
                0:       wgt = $urandom();
                1:       wgt = $urandom_range(1);
                default: wgt = $urandom_range(40);
            endcase
            queue_request(mwua_pkg::t_action'($urandom_range(3)), idx,
                          mwua_pkg::UPD_W'($urandom()), wgt);
        end
    endtask

    initial begin
        int unsigned phase;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = mwua_pkg::REG_ELEMENT_COUNT;
        i_cfg_data     = '0;
        i_out_ready    = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = mwua_pkg::ACT_READ;
        i_element_index = '0;
        i_update_value = '0;
        i_weight_value = '0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        failures       = 0;
        shadow_count   = '0;
        shadow_enabled = 1'b0;
        foreach (shadow_store[i]) shadow_store[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset the block is disabled: everything is rejected.
        queue_request(mwua_pkg::ACT_READ, 0, 16'sd0, 32'd0);
        queue_request(mwua_pkg::ACT_CLEAR, 0, 16'sd0, 32'd0);
        queue_request(mwua_pkg::ACT_ACCUMULATE, 0, 16'sd5, 32'd3);
        drain();

        // Directed part on a small store: extremes of the update and weight,
        // zero total weight, the range boundary and every action.
        write_register(mwua_pkg::REG_ELEMENT_COUNT, 13'd8);
        write_register(mwua_pkg::REG_ENABLED, 13'd1);
        queue_request(mwua_pkg::ACT_ACCUMULATE, 0, 16'sh8000, 32'hFFFF_FFFF);
        queue_request(mwua_pkg::ACT_ACCUMULATE, 0, 16'sd32767, 32'hFFFF_FFFF);
        queue_request(mwua_pkg::ACT_ACCUMULATE, 1, -16'sd1, 32'd1);
        queue_request(mwua_pkg::ACT_ACCUMULATE, 2, 16'sd32767, 32'd0);
        queue_request(mwua_pkg::ACT_READ, 0, 16'sd0, 32'd0);
        queue_request(mwua_pkg::ACT_FINALIZE, 0, 16'sd0, 32'd0);
        queue_request(mwua_pkg::ACT_FINALIZE, 0, 16'sd0, 32'd3);
        queue_request(mwua_pkg::ACT_FINALIZE, 1, 16'sd0, 32'd1);
        queue_request(mwua_pkg::ACT_FINALIZE, 0, 16'sd0, 32'hFFFF_FFFF);
        queue_request(mwua_pkg::ACT_ACCUMULATE, 7, -16'sd3000, 32'd1);
        queue_request(mwua_pkg::ACT_FINALIZE, 7, 16'sd0, 32'd7);
        queue_request(mwua_pkg::ACT_CLEAR, 7, 16'sd0, 32'd0);
        queue_request(mwua_pkg::ACT_READ, 8, 16'sd0, 32'd0);
        queue_request(mwua_pkg::ACT_ACCUMULATE, STORE_DEPTH - 1, 16'sd1, 32'd1);
        queue_request(mwua_pkg::ACT_READ, 7, 16'sd0, 32'd0);
        drain();

        // The whole store in range, with the top element reachable.
        write_register(mwua_pkg::REG_ELEMENT_COUNT, 13'd4096);
        queue_request(mwua_pkg::ACT_ACCUMULATE, STORE_DEPTH - 1, 16'sh8000, 32'd2);
        queue_request(mwua_pkg::ACT_READ, STORE_DEPTH - 1, 16'sd0, 32'd0);
        queue_request(mwua_pkg::ACT_CLEAR, STORE_DEPTH - 1, 16'sd0, 32'd0);
        drain();

        // Random phases, each with a chosen count and idling pattern; phase 5 runs disabled.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 79; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 79; end
                default: begin send_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            case (phase)
                0: write_register(mwua_pkg::REG_ELEMENT_COUNT, 13'd8191);
                1: write_register(mwua_pkg::REG_ELEMENT_COUNT, 13'd0);
                2: write_register(mwua_pkg::REG_ELEMENT_COUNT, 13'd1);
                3: write_register(mwua_pkg::REG_ELEMENT_COUNT, 13'd4095);
                default: write_register(mwua_pkg::REG_ELEMENT_COUNT,
                                        mwua_pkg::COUNT_W'($urandom_range(2, 300)));
            endcase
            write_register(mwua_pkg::REG_ENABLED, (phase == 5) ? 13'd0 : 13'd1);
            queue_random((phase == 1 || phase == 5) ? 40 : 175);
            drain();
        end

        if (failures == 0) begin
            $display("modular_weighted_update_accumulator test passed");
        end else begin
            $display("modular_weighted_update_accumulator test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("modular_weighted_update_accumulator test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/mwua_pkg.sv
src/mwua_ram.sv
src/modular_weighted_update_accumulator.sv
tb/tb_modular_weighted_update_accumulator.sv
